@@ rtl/lmt_pkg.sv @@
package lmt_pkg;

   // Dot thresholds for each mode and the line numbers that bound vblank.
   localparam logic [9:0] DOTS_OAM          = 10'd80;
   localparam logic [9:0] DOTS_XFER         = 10'd172;
   localparam logic [9:0] DOTS_HBLANK       = 10'd204;
   localparam logic [9:0] DOTS_LINE         = 10'd456;
   localparam logic [7:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [7:0] LAST_LINE         = 8'd153;

   // Mode codes as they appear on the result channel.
   localparam logic [1:0] MODE_HBLANK = 2'd0;
   localparam logic [1:0] MODE_VBLANK = 2'd1;
   localparam logic [1:0] MODE_OAM    = 2'd2;
   localparam logic [1:0] MODE_XFER   = 2'd3;

   // Internal mode sequencer state.
   typedef enum logic [3:0] {
      ST_HBLANK = 4'b0001,
      ST_VBLANK = 4'b0010,
      ST_OAM    = 4'b0100,
      ST_XFER   = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [5:0] cycles;
      logic       lcd_enable;
      logic       hblank_int_enable;
      logic       compare_int_enable;
      logic [7:0] compare_line;
   } req_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] line;
      logic       render_strobe;
      logic       vblank_irq;
      logic       stat_irq;
      logic       frame_done;
   } rsp_type;

   // Timing state carried from one transaction to the next.
   typedef struct packed {
      phase_type  phase;
      logic [9:0] dots;
      logic [7:0] line;
   } timing_type;

   function automatic logic [1:0] mode_of(input phase_type phase);
      logic [1:0] code;
      unique case (phase)
         ST_HBLANK: code = MODE_HBLANK;
         ST_VBLANK: code = MODE_VBLANK;
         ST_OAM:    code = MODE_OAM;
         ST_XFER:   code = MODE_XFER;
         default:   code = MODE_OAM;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/lmt_step.sv @@
module lmt_step
   import lmt_pkg::*;
(
   input  timing_type cur,
   input  req_type    req,
   output timing_type nxt,
   output rsp_type    rsp
);

   logic [9:0] dots_sum;
   logic [7:0] line_inc;
   logic       line_changed;
   logic       strobe;
   logic       vbl;
   logic       stat_hblank;

   // Accumulate the tick's cycles; the counter wraps at ten bits.
   assign dots_sum = cur.dots + {4'd0, req.cycles};
   assign line_inc = cur.line + 8'd1;

   // At most one mode transition per transaction; leftover dots carry over.
   always_comb begin
      nxt          = cur;
      nxt.dots     = dots_sum;
      line_changed = 1'b0;
      strobe       = 1'b0;
      vbl          = 1'b0;
      stat_hblank  = 1'b0;
      if (!req.lcd_enable) begin
         nxt.phase = ST_OAM;
         nxt.dots  = '0;
      end else begin
         unique case (cur.phase)
            ST_OAM: begin
               if (dots_sum >= DOTS_OAM) begin
                  nxt.dots  = dots_sum - DOTS_OAM;
                  nxt.phase = ST_XFER;
               end
            end
            ST_XFER: begin
               if (dots_sum >= DOTS_XFER) begin
                  nxt.dots    = dots_sum - DOTS_XFER;
                  nxt.phase   = ST_HBLANK;
                  strobe      = 1'b1;
                  stat_hblank = req.hblank_int_enable;
               end
            end
            ST_HBLANK: begin
               if (dots_sum >= DOTS_HBLANK) begin
                  nxt.dots     = dots_sum - DOTS_HBLANK;
                  nxt.line     = line_inc;
                  line_changed = 1'b1;
                  if (line_inc == FIRST_VBLANK_LINE) begin
                     nxt.phase = ST_VBLANK;
                     vbl       = 1'b1;
                  end else begin
                     nxt.phase = ST_OAM;
                  end
               end
            end
            ST_VBLANK: begin
               if (dots_sum >= DOTS_LINE) begin
                  nxt.dots     = dots_sum - DOTS_LINE;
                  line_changed = 1'b1;
                  if (line_inc > LAST_LINE) begin
                     nxt.line  = '0;
                     nxt.phase = ST_OAM;
                  end else begin
                     nxt.line = line_inc;
                  end
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end
   end

   // Assemble the result; the compare match looks at the new line only.
   always_comb begin
      rsp.mode          = mode_of(nxt.phase);
      rsp.line          = nxt.line;
      rsp.render_strobe = strobe;
      rsp.vblank_irq    = vbl;
      rsp.frame_done    = vbl;
      rsp.stat_irq      = stat_hblank
                          | (line_changed & req.compare_int_enable
                             & (nxt.line == req.compare_line));
   end

endmodule

@@ rtl/lcd_mode_line_timing.sv @@
// LCD mode and line timing sequencer.
//
// Each transaction on the req_ channel is one tick: the machine cycles since
// the previous tick plus the live enable bits and the compare line. The block
// adds the cycles to its dot counter, advances the mode (OAM scan, transfer,
// hblank, vblank) by at most one step, and returns one transaction on the
// rsp_ channel with the new mode and line and the event pulses.
// The result is registered: a tick accepted at a clock edge gives its result on
// rsp_valid right after that edge. Throughput is one tick per cycle while the
// receiver does not stall; the next-state logic is a single add, compare and
// subtract between the timing registers and the result register.
// The result register is the only buffer: req_ready is high while it is
// empty or being drained, so a stalled receiver holds the result and
// back-pressures the sender without losing a tick.
// Synchronous reset puts the sequencer in OAM scan at line 0 with the dot
// counter cleared and empties the result register.
module lcd_mode_line_timing
   import lmt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   timing_type timing_ff;
   timing_type timing_in;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Next timing state and result for the offered tick.
   lmt_step u_step (
      .cur (timing_ff),
      .req (req_data),
      .nxt (timing_in),
      .rsp (rsp_in)
   );

   // Result register valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Timing state advances on each accepted transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.phase <= ST_OAM;
         timing_ff.dots  <= '0;
         timing_ff.line  <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            timing_ff <= timing_in;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // A frame is finished only on entry to vblank at the first vblank line.
   a_frame_at_vblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_done |->
         rsp_data.vblank_irq && rsp_data.line == FIRST_VBLANK_LINE
         && rsp_data.mode == MODE_VBLANK)
      else $error("frame_done without vblank entry");

   // The end of transfer always lands in hblank.
   a_strobe_hblank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.render_strobe |-> rsp_data.mode == MODE_HBLANK)
      else $error("render_strobe outside hblank");

   // In vblank the line counter stays within the vblank lines.
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      timing_ff.phase == ST_VBLANK |->
         timing_ff.line >= FIRST_VBLANK_LINE && timing_ff.line <= LAST_LINE)
      else $error("line counter out of range in vblank");

   // A held result does not change while the receiver stalls.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");
`endif

endmodule

@@ sim/lcd_mode_line_timing_test.sv @@
`timescale 1ns / 1ps

module lcd_mode_line_timing_test;
   import lmt_pkg::*;

   // Directed script: one tick per row, with the result typed in where it is obvious.
   typedef struct packed {
      req_type tick;
      logic    known;
      rsp_type result;
   } script_row_type;

   localparam rsp_type NO_RESULT = '0;
   localparam int SCRIPT_ROWS = 25;
   localparam int RANDOM_TICKS = 625;
   localparam int MAX_REPORTS = 10;

   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      // Right after reset: no transition, still in OAM scan on line 0.
      '{'{6'd0,  1'b1, 1'b0, 1'b0, 8'd0},   1'b1, '{MODE_OAM, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // LCD off with every other field at its top value.
      '{'{6'd63, 1'b0, 1'b1, 1'b1, 8'd255}, 1'b1, '{MODE_OAM, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{6'd63, 1'b1, 1'b0, 1'b0, 8'd0},   1'b1, '{MODE_OAM, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Exactly 80 dots ends OAM scan.
      '{'{6'd17, 1'b1, 1'b0, 1'b0, 8'd0},   1'b1, '{MODE_XFER, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{6'd63, 1'b1, 1'b1, 1'b0, 8'hAA},  1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b1, 1'b0, 8'h55},  1'b0, NO_RESULT},
      // Transfer ends at 172 dots with the hblank status interrupt enabled.
      '{'{6'd46, 1'b1, 1'b1, 1'b0, 8'd0},   1'b1, '{MODE_HBLANK, 8'd0, 1'b1, 1'b0, 1'b1, 1'b0}},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd1},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd1},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd1},   1'b0, NO_RESULT},
      // Hblank ends at 204 dots and the new line matches the compare line.
      '{'{6'd15, 1'b1, 1'b0, 1'b1, 8'd1},   1'b1, '{MODE_OAM, 8'd1, 1'b0, 1'b0, 1'b1, 1'b0}},
      '{'{6'd63, 1'b1, 1'b0, 1'b0, 8'd0},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b0, 8'd0},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b0, 8'd0},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b0, 8'd0},   1'b0, NO_RESULT},
      // LCD off in hblank: back to OAM scan, the line holds.
      '{'{6'd63, 1'b0, 1'b1, 1'b1, 8'd1},   1'b1, '{MODE_OAM, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
      // Compare matches but the line does not change, so no interrupt.
      '{'{6'd0,  1'b1, 1'b1, 1'b1, 8'd1},   1'b1, '{MODE_OAM, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0}},
      '{'{6'd40, 1'b1, 1'b1, 1'b1, 8'hF0},  1'b0, NO_RESULT},
      '{'{6'd40, 1'b1, 1'b1, 1'b1, 8'h0F},  1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b1, 1'b0, 8'd2},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b1, 1'b0, 8'd2},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b1, 1'b0, 8'd2},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd2},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd2},   1'b0, NO_RESULT},
      '{'{6'd63, 1'b1, 1'b0, 1'b1, 8'd2},   1'b0, NO_RESULT}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Timing state of the predictor.
   logic [1:0] tm_mode = MODE_OAM;
   logic [9:0] tm_dots = '0;
   logic [7:0] tm_line = '0;

   rsp_type pending_results [$];
   int      failures = 0;
   int      ticks_sent = 0;
   int      frames_seen = 0;
   int      line_wraps = 0;
   int      stat_pulses = 0;
   int      render_strobes = 0;
   int      lcd_off_ticks = 0;
   int      results_checked = 0;

   lcd_mode_line_timing u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock generation.
   initial begin
      forever #5 clock = ~clock;
   end

   // Advances the timing state by one tick and returns the resulting mode, line and pulses.
   function automatic rsp_type advance_timing(input req_type t);
      rsp_type r;
      logic    line_moved;
      r = '0;
      line_moved = 1'b0;
      tm_dots = tm_dots + {4'b0, t.cycles};
      if (t.lcd_enable) begin
         case (tm_mode)
            MODE_OAM: begin
               if (tm_dots >= DOTS_OAM) begin
                  tm_dots = tm_dots - DOTS_OAM;
                  tm_mode = MODE_XFER;
               end
            end
            MODE_XFER: begin
               if (tm_dots >= DOTS_XFER) begin
                  tm_dots = tm_dots - DOTS_XFER;
                  tm_mode = MODE_HBLANK;
                  r.render_strobe = 1'b1;
                  r.stat_irq = t.hblank_int_enable;
               end
            end
            MODE_HBLANK: begin
               if (tm_dots >= DOTS_HBLANK) begin
                  tm_dots = tm_dots - DOTS_HBLANK;
                  tm_line = tm_line + 8'd1;
                  line_moved = 1'b1;
                  if (tm_line == FIRST_VBLANK_LINE) begin
                     tm_mode = MODE_VBLANK;
                     r.vblank_irq = 1'b1;
                     r.frame_done = 1'b1;
                  end else begin
                     tm_mode = MODE_OAM;
                  end
               end
            end
            default: begin
               if (tm_dots >= DOTS_LINE) begin
                  tm_dots = tm_dots - DOTS_LINE;
                  tm_line = tm_line + 8'd1;
                  line_moved = 1'b1;
                  if (tm_line > LAST_LINE) begin
                     tm_line = '0;
                     tm_mode = MODE_OAM;
                  end
               end
            end
         endcase
         if (line_moved && tm_line == t.compare_line && t.compare_int_enable) begin
            r.stat_irq = 1'b1;
         end
      end else begin
         tm_mode = MODE_OAM;
         tm_dots = '0;
      end
      r.mode = tm_mode;
      r.line = tm_line;
      return r;
   endfunction

   // Counts a failure and reports the first few.
   function automatic void flag_failure(input string msg);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("[%0t] error: %s", $realtime, msg);
      end
   endfunction

   // Draws an idle gap; some stretches run with no idling at all.
   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 15);
   endfunction

   // Sends one tick and records what it should produce once the block accepts it.
   task automatic send_tick(input req_type t, input logic known, input rsp_type fixed,
                            input bit calm);
      int      gap;
      logic    was_wrap;
      rsp_type predicted;
      gap = draw_gap(calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      was_wrap = (tm_line == LAST_LINE);
      predicted = advance_timing(t);
      pending_results.push_back(known ? fixed : predicted);
      ticks_sent++;
      if (predicted.frame_done) frames_seen++;
      if (was_wrap && predicted.line == 8'd0 && t.lcd_enable) line_wraps++;
      if (predicted.stat_irq) stat_pulses++;
      if (predicted.render_strobe) render_strobes++;
      if (!t.lcd_enable) lcd_off_ticks++;
   endtask

   // Result side: random stalls, then each transaction is checked against the oldest expectation.
   initial begin : result_drain
      int      gap;
      int      count;
      bit      calm;
      rsp_type want;
      count = 0;
      calm = 1'b0;
      wait (!reset);
      forever begin
         if (count % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         count++;
         gap = draw_gap(calm);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (pending_results.size() == 0) begin
            flag_failure($sformatf("unexpected result mode=%0d line=%0d",
                                   rsp_data.mode, rsp_data.line));
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_data.mode !== want.mode || rsp_data.line !== want.line ||
                rsp_data.render_strobe !== want.render_strobe ||
                rsp_data.vblank_irq !== want.vblank_irq ||
                rsp_data.stat_irq !== want.stat_irq ||
                rsp_data.frame_done !== want.frame_done) begin
               flag_failure($sformatf({"result %0d: expected mode=%0d line=%0d strobe=%b ",
                  "vbl=%b stat=%b frame=%b, got mode=%0d line=%0d strobe=%b vbl=%b ",
                  "stat=%b frame=%b"}, results_checked,
                  want.mode, want.line, want.render_strobe, want.vblank_irq,
                  want.stat_irq, want.frame_done,
                  rsp_data.mode, rsp_data.line, rsp_data.render_strobe,
                  rsp_data.vblank_irq, rsp_data.stat_irq, rsp_data.frame_done));
            end
         end
      end
   end

   // Reset, directed script, random ticks, then drain and report.
   initial begin : tick_source
      req_type t;
      int      n;
      int      pick;
      int      guard;
      bit      calm;
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (n = 0; n < SCRIPT_ROWS; n++) begin
         send_tick(SCRIPT[n].tick, SCRIPT[n].known, SCRIPT[n].result, n < 8);
      end

      // Mostly long ticks with the LCD running, so that many lines go by;
      // the LCD drops out now and then and the compare line often targets the next line.
      calm = 1'b0;
      for (n = 0; n < RANDOM_TICKS; n++) begin
         if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 9);
         if (pick < 7) t.cycles = 6'($urandom_range(32, 63));
         else if (pick < 9) t.cycles = 6'($urandom_range(0, 63));
         else t.cycles = $urandom_range(0, 1) ? 6'd63 : 6'd0;
         t.lcd_enable = ($urandom_range(0, 149) != 0);
         t.hblank_int_enable = 1'($urandom_range(0, 1));
         t.compare_int_enable = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 1)) t.compare_line = tm_line + 8'd1;
         else t.compare_line = 8'($urandom_range(0, 255));
         send_tick(t, 1'b0, NO_RESULT, calm);
      end
      req_valid <= 1'b0;

      guard = 0;
      while (pending_results.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (5) @(posedge clock);
      if (pending_results.size() != 0) begin
         flag_failure($sformatf("%0d results never arrived", pending_results.size()));
      end

      $display("Sent %0d ticks (%0d scripted), checked %0d results.",
               ticks_sent, SCRIPT_ROWS, results_checked);
      $display("Saw %0d frames, %0d line wraps, %0d renders, %0d status irqs, %0d ticks off.",
               frames_seen, line_wraps, render_strobes, stat_pulses, lcd_off_ticks);
      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d failures", failures);
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      #6000000;
      $display("timeout");
      $display("== FAIL ==");
      $finish;
   end

endmodule
